FILE: rtl/fdwt_pkg.sv
`default_nettype none

package fdwt_pkg;

    // Geometry defaults
    localparam int MaxWidthDefault  = 512;
    localparam int MaxHeightDefault = 512;
    localparam int GeomResetVal     = 512;

    // Field widths
    localparam int GEOM_W     = 10;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int PIXEL_W    = 16;
    localparam int OFFSET_W   = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Command codes
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Result codes
    localparam logic RES_FLUSH = 1'b0;
    localparam logic RES_READ  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_MEM,
        ST_DONE,
        ST_FLUSH
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic calc_addr;
        logic mem_read;
        logic finish_write;
        logic finish_read;
        logic flush;
        logic clear_step;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_read;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/fdwt_ctrl.sv
`default_nettype none

module fdwt_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fdwt_pkg::KIND_W-1:0] kind,
    input  wire fdwt_pkg::stat_t             stat,
    output fdwt_pkg::cmd_t                   cmd,
    output logic                             busy
);

    fdwt_pkg::state_t state_reg;
    fdwt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdwt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            fdwt_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = fdwt_pkg::ST_IDLE;
                end
            end
            fdwt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (kind)
                        fdwt_pkg::KIND_WRITE: state_next = fdwt_pkg::ST_ADDR;
                        fdwt_pkg::KIND_READ:  state_next = fdwt_pkg::ST_ADDR;
                        fdwt_pkg::KIND_FLUSH: state_next = fdwt_pkg::ST_FLUSH;
                        default:              state_next = fdwt_pkg::ST_IDLE;
                    endcase
                end
            end
            fdwt_pkg::ST_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = fdwt_pkg::ST_MEM;
            end
            fdwt_pkg::ST_MEM:
            begin
                cmd.mem_read = 1'b1;
                state_next   = fdwt_pkg::ST_DONE;
            end
            fdwt_pkg::ST_DONE:
            begin
                if (stat.is_read)
                begin
                    cmd.finish_read = 1'b1;
                end
                else
                begin
                    cmd.finish_write = 1'b1;
                end
                state_next = fdwt_pkg::ST_IDLE;
            end
            fdwt_pkg::ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = fdwt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fdwt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/fdwt_datapath.sv
`default_nettype none

module fdwt_datapath #(
    parameter int MAX_WIDTH  = fdwt_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = fdwt_pkg::MaxHeightDefault
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fdwt_pkg::cmd_t                    cmd,
    output fdwt_pkg::stat_t                        stat,
    input  wire logic                              cfg_we,
    input  wire logic [fdwt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fdwt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [fdwt_pkg::KIND_W-1:0]       kind,
    input  wire logic signed [fdwt_pkg::COORD_W-1:0] pixel_x,
    input  wire logic signed [fdwt_pkg::COORD_W-1:0] pixel_y,
    input  wire logic [fdwt_pkg::COLOR_W-1:0]      red,
    input  wire logic [fdwt_pkg::COLOR_W-1:0]      green,
    input  wire logic [fdwt_pkg::COLOR_W-1:0]      blue,
    output logic                                   result_valid,
    output logic                                   result_kind,
    output logic                                   window_valid,
    output logic [fdwt_pkg::OFFSET_W-1:0]          window_x_start,
    output logic [fdwt_pkg::OFFSET_W-1:0]          window_y_start,
    output logic [fdwt_pkg::OFFSET_W-1:0]          window_x_end,
    output logic [fdwt_pkg::OFFSET_W-1:0]          window_y_end,
    output logic [fdwt_pkg::PIXEL_W-1:0]           pixel_value
);

    localparam int GW     = fdwt_pkg::GEOM_W;
    localparam int CW     = fdwt_pkg::COORD_W;
    localparam int OW     = fdwt_pkg::OFFSET_W;
    localparam int PW     = fdwt_pkg::PIXEL_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [GW-1:0] RST_W = GW'((MAX_WIDTH < fdwt_pkg::GeomResetVal) ?
                                          MAX_WIDTH : fdwt_pkg::GeomResetVal);
    localparam logic [GW-1:0] RST_H = GW'((MAX_HEIGHT < fdwt_pkg::GeomResetVal) ?
                                          MAX_HEIGHT : fdwt_pkg::GeomResetVal);

    // Config
    logic [GW-1:0] width_reg;
    logic [GW-1:0] height_reg;
    logic [OW-1:0] col_off_reg;
    logic [OW-1:0] row_off_reg;
    logic [GW-1:0] eff_w;
    logic [GW-1:0] eff_h;

    // Captured command
    logic [fdwt_pkg::KIND_W-1:0] kind_reg;
    logic [CW-1:0]               x_reg;
    logic [CW-1:0]               y_reg;
    logic [PW-1:0]               color_reg;

    // Address stage
    logic [2*GW-1:0]   prod;
    logic [2*GW:0]     addr_sum;
    logic              inb_next;
    logic              inb_reg;
    logic [ADDR_W-1:0] idx_reg;

    // Frame store
    logic [PW-1:0]     mem [DEPTH];
    logic [PW-1:0]     rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PW-1:0]     mem_wdata;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic              changed;

    // Dirty marks
    logic [GW-1:0] x_low_reg;
    logic [GW-1:0] y_low_reg;
    logic [GW-1:0] x_high_reg;
    logic [GW-1:0] y_high_reg;
    logic [GW-1:0] xl;
    logic [GW-1:0] yl;
    logic [GW-1:0] xh;
    logic [GW-1:0] yh;
    logic          win_ok;

    // Result
    logic          result_valid_reg;
    logic          result_kind_reg;
    logic          window_valid_reg;
    logic [OW-1:0] wxs_reg;
    logic [OW-1:0] wys_reg;
    logic [OW-1:0] wxe_reg;
    logic [OW-1:0] wye_reg;
    logic [PW-1:0] pixel_reg;

    // Widths above the compile-time maximum clamp to it
    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? GW'(MAX_WIDTH) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? GW'(MAX_HEIGHT) : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= GW'(fdwt_pkg::GeomResetVal);
            height_reg  <= GW'(fdwt_pkg::GeomResetVal);
            col_off_reg <= '0;
            row_off_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdwt_pkg::REG_PANEL_WIDTH:   width_reg   <= cfg_data[GW-1:0];
                fdwt_pkg::REG_PANEL_HEIGHT:  height_reg  <= cfg_data[GW-1:0];
                fdwt_pkg::REG_COLUMN_OFFSET: col_off_reg <= cfg_data[OW-1:0];
                fdwt_pkg::REG_ROW_OFFSET:    row_off_reg <= cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            x_reg     <= pixel_x;
            y_reg     <= pixel_y;
            color_reg <= {red[7:3], green[7:2], blue[7:3]};
        end
    end

    assign stat.is_read    = (kind_reg == fdwt_pkg::KIND_READ);
    assign stat.clear_last = (clear_cnt_reg == LAST_ADDR);

    // Linear index = y * stride + x; only meaningful when in bounds
    assign prod     = y_reg[GW-1:0] * eff_w;
    assign addr_sum = {1'b0, prod} + (2*GW+1)'(x_reg[GW-1:0]);
    assign inb_next = !x_reg[CW-1] && !y_reg[CW-1]
                   && (x_reg < CW'(eff_w)) && (y_reg < CW'(eff_h));

    always_ff @(posedge clk)
    begin
        if (cmd.calc_addr)
        begin
            idx_reg <= ADDR_W'(addr_sum);
            inb_reg <= inb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    assign changed   = (rdata_reg != color_reg);
    assign mem_we    = cmd.clear_step || (cmd.finish_write && inb_reg && changed);
    assign mem_addr  = cmd.clear_step ? clear_cnt_reg : idx_reg;
    assign mem_wdata = cmd.clear_step ? '0 : color_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Flush rounds to even/odd pixel pairs
    assign xl     = {x_low_reg[GW-1:1], 1'b0};
    assign yl     = {y_low_reg[GW-1:1], 1'b0};
    assign xh     = {x_high_reg[GW-1:1], 1'b1};
    assign yh     = {y_high_reg[GW-1:1], 1'b1};
    assign win_ok = (xh >= xl) && (yh >= yl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= RST_W;
            y_low_reg  <= RST_H;
            x_high_reg <= '0;
            y_high_reg <= '0;
        end
        else if (cmd.flush)
        begin
            x_low_reg  <= eff_w;
            y_low_reg  <= eff_h;
            x_high_reg <= '0;
            y_high_reg <= '0;
        end
        else if (cmd.finish_write && inb_reg && changed)
        begin
            if (x_reg[GW-1:0] < x_low_reg)  x_low_reg  <= x_reg[GW-1:0];
            if (y_reg[GW-1:0] < y_low_reg)  y_low_reg  <= y_reg[GW-1:0];
            if (x_reg[GW-1:0] > x_high_reg) x_high_reg <= x_reg[GW-1:0];
            if (y_reg[GW-1:0] > y_high_reg) y_high_reg <= y_reg[GW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.flush || cmd.finish_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush)
        begin
            result_kind_reg  <= fdwt_pkg::RES_FLUSH;
            window_valid_reg <= win_ok;
            wxs_reg          <= win_ok ? OW'(xl) + col_off_reg : '0;
            wys_reg          <= win_ok ? OW'(yl) + row_off_reg : '0;
            wxe_reg          <= win_ok ? OW'(xh) + col_off_reg : '0;
            wye_reg          <= win_ok ? OW'(yh) + row_off_reg : '0;
            pixel_reg        <= '0;
        end
        else if (cmd.finish_read)
        begin
            result_kind_reg  <= fdwt_pkg::RES_READ;
            window_valid_reg <= 1'b0;
            wxs_reg          <= '0;
            wys_reg          <= '0;
            wxe_reg          <= '0;
            wye_reg          <= '0;
            pixel_reg        <= inb_reg ? rdata_reg : '0;
        end
    end

    assign result_valid   = result_valid_reg;
    assign result_kind    = result_kind_reg;
    assign window_valid   = window_valid_reg;
    assign window_x_start = wxs_reg;
    assign window_y_start = wys_reg;
    assign window_x_end   = wxe_reg;
    assign window_y_end   = wye_reg;
    assign pixel_value    = pixel_reg;

`ifndef SYNTH
    // Each item returns to idle before the next is accepted, so strobes never abut
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe on consecutive cycles");

    // Only in-bounds writes or the clearing sweep touch the frame store
    a_write_inb: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !cmd.clear_step) |-> inb_reg)
        else $error("frame store write out of bounds");

    // A flush leaves the high marks at zero
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (x_high_reg == '0) && (y_high_reg == '0))
        else $error("dirty marks not reset by flush");

    // A valid window only comes with a flush result
    a_window_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && window_valid_reg) |-> (result_kind_reg == fdwt_pkg::RES_FLUSH))
        else $error("window_valid on a read result");
`endif

endmodule

`default_nettype wire

FILE: rtl/framebuffer_dirty_window_tracker.sv
// Pixel write and pixel read: accepted while idle, then busy in the address, memory and
// done states; a read result strobes on the cycle after the last busy cycle. Flush:
// busy in the flush state, result registered after it. No new command is accepted until
// the last is done. Pixel ops use the frame store read-compare-write (address multiply,
// registered read, conditional write). Reset: asynchronous, active low; afterwards the
// frame store is swept to zero with busy high. Results cannot be stalled by the receiver.
`default_nettype none

module framebuffer_dirty_window_tracker #(
    parameter int MAX_WIDTH  = fdwt_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = fdwt_pkg::MaxHeightDefault
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [fdwt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fdwt_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Command side: transfer when start && !busy
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [fdwt_pkg::KIND_W-1:0]         kind,
    input  wire logic signed [fdwt_pkg::COORD_W-1:0] pixel_x,
    input  wire logic signed [fdwt_pkg::COORD_W-1:0] pixel_y,
    input  wire logic [fdwt_pkg::COLOR_W-1:0]        red,
    input  wire logic [fdwt_pkg::COLOR_W-1:0]        green,
    input  wire logic [fdwt_pkg::COLOR_W-1:0]        blue,

    // Result side: one-cycle strobe per read or flush transfer
    output logic                                     result_valid,
    output logic                                     result_kind,
    output logic                                     window_valid,
    output logic [fdwt_pkg::OFFSET_W-1:0]            window_x_start,
    output logic [fdwt_pkg::OFFSET_W-1:0]            window_y_start,
    output logic [fdwt_pkg::OFFSET_W-1:0]            window_x_end,
    output logic [fdwt_pkg::OFFSET_W-1:0]            window_y_end,
    output logic [fdwt_pkg::PIXEL_W-1:0]             pixel_value
);

    // Controller sequences each command; datapath holds config, the
    // frame store, dirty marks and the result registers.
    fdwt_pkg::cmd_t  cmd;
    fdwt_pkg::stat_t stat;

    fdwt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fdwt_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .result_valid   (result_valid),
        .result_kind    (result_kind),
        .window_valid   (window_valid),
        .window_x_start (window_x_start),
        .window_y_start (window_y_start),
        .window_x_end   (window_x_end),
        .window_y_end   (window_y_end),
        .pixel_value    (pixel_value)
    );

endmodule

`default_nettype wire
